>>> rtl/core/wrs_pkg.sv
package wrs_pkg;

    // Widths fixed by the item fields
    localparam int VAL_W     = 16;
    localparam int WT_W      = 16;
    localparam int RND_W     = 32;
    localparam int DIV_CNT_W = $clog2(RND_W);

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_SET   = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_RD,
        S_CHK,
        S_WR,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic div_step;
        logic chk;
        logic idx_inc;
        logic wr;
        logic out_load;
    } wrs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic total_zero;
        logic count_zero;
        logic div_last;
        logic found;
        logic last;
    } wrs_stat_t;

endpackage

>>> rtl/core/wrs_ram.sv
module wrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/wrs_ctrl.sv
module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  wrs_stat_t stat,
    output wrs_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_DRAW:
                    begin
                        state_next = stat.total_zero ? S_DONE : S_DIV;
                    end
                    OP_SET:
                    begin
                        state_next = stat.count_zero ? S_WR : S_RD;
                    end
                    OP_QUERY:
                    begin
                        state_next = stat.count_zero ? S_DONE : S_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.found || stat.last)
                begin
                    state_next = (stat.op == OP_SET) ? S_WR : S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.load     = in_valid;
            S_DECODE: cmd.clear    = (stat.op == OP_CLEAR);
            S_DIV:    cmd.div_step = 1'b1;
            S_RD:     cmd          = '0;
            S_CHK:
            begin
                cmd.chk     = 1'b1;
                cmd.idx_inc = !stat.found && !stat.last;
            end
            S_WR:     cmd.wr       = 1'b1;
            S_DONE:   cmd.out_load = out_free;
            default:  cmd          = '0;
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/wrs_dp.sv
module wrs_dp
    import wrs_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              opcode,
    input  logic signed [VAL_W-1:0] item_value,
    input  logic [WT_W-1:0]         item_weight,
    input  logic [RND_W-1:0]        random_word,
    output logic signed [VAL_W-1:0] chosen_value,
    output logic [WT_W-1:0]         weight_out,
    output logic                    hit,
    output logic                    table_full_error,
    input  wrs_cmd_t                cmd,
    output wrs_stat_t               stat
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int TOT_W = WT_W + $clog2(ENTRIES);

    op_t                  op_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [WT_W-1:0]      wt_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic [RND_W-1:0]     rnd_next;
    logic [TOT_W-1:0]     rem_reg;
    logic [TOT_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [TOT_W-1:0]     base_reg;
    logic [TOT_W-1:0]     base_next;
    logic                 found_reg;
    logic                 found_next;
    logic                 err_reg;
    logic                 err_next;
    logic [VAL_W-1:0]     sel_val_reg;
    logic [VAL_W-1:0]     sel_val_next;
    logic [WT_W-1:0]      sel_wt_reg;
    logic [WT_W-1:0]      sel_wt_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TOT_W-1:0]     total_reg;
    logic [TOT_W-1:0]     total_next;

    logic [VAL_W-1:0]     chosen_reg;
    logic [WT_W-1:0]      wout_reg;
    logic                 hit_reg;
    logic                 err_out_reg;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [VAL_W+WT_W-1:0] ram_rd_data;
    logic [VAL_W-1:0]     rd_val;
    logic [WT_W-1:0]      rd_wt;

    logic [TOT_W:0]       trial;
    logic [TOT_W:0]       trial_diff;
    logic [TOT_W:0]       range_end;
    logic                 found_now;
    logic                 full;

    wrs_ram #(
        .WIDTH (VAL_W + WT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({val_reg, wt_reg}),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_val = ram_rd_data[VAL_W+WT_W-1:WT_W];
    assign rd_wt  = ram_rd_data[WT_W-1:0];

    // One restoring division step: shift in one dividend bit
    assign trial      = {rem_reg, rnd_reg[RND_W-1]};
    assign trial_diff = trial - {1'b0, total_reg};

    // Cumulative range end of the entry under inspection
    assign range_end = {1'b0, base_reg} + (TOT_W + 1)'(rd_wt);

    assign found_now = (op_reg == OP_DRAW) ? ({1'b0, rem_reg} < range_end)
                                           : (rd_val == val_reg);
    assign full      = (count_reg == CNT_W'(ENTRIES));

    // Write the matched entry in place, else append while the table is not full
    assign ram_wr_en   = cmd.wr && (found_reg || !full);
    assign ram_wr_addr = found_reg ? idx_reg : count_reg[IDX_W-1:0];

    // Status
    assign stat.op         = op_reg;
    assign stat.total_zero = (total_reg == '0);
    assign stat.count_zero = (count_reg == '0);
    assign stat.div_last   = (div_cnt_reg == DIV_CNT_W'(RND_W - 1));
    assign stat.found      = found_now;
    assign stat.last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Next values
    always_comb
    begin
        rnd_next     = rnd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        sel_val_next = sel_val_reg;
        sel_wt_next  = sel_wt_reg;
        count_next   = count_reg;
        total_next   = total_reg;

        if (cmd.load)
        begin
            rnd_next     = random_word;
            rem_next     = '0;
            div_cnt_next = '0;
            idx_next     = '0;
            base_next    = '0;
            found_next   = 1'b0;
            err_next     = 1'b0;
        end

        if (cmd.clear)
        begin
            count_next = '0;
            total_next = '0;
        end

        if (cmd.div_step)
        begin
            rnd_next     = {rnd_reg[RND_W-2:0], 1'b0};
            rem_next     = trial_diff[TOT_W] ? trial[TOT_W-1:0] : trial_diff[TOT_W-1:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.chk)
        begin
            found_next   = found_now;
            sel_val_next = rd_val;
            sel_wt_next  = rd_wt;
            base_next    = range_end[TOT_W-1:0];
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.wr)
        begin
            if (found_reg)
            begin
                total_next = total_reg - TOT_W'(sel_wt_reg) + TOT_W'(wt_reg);
            end
            else if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
                total_next = total_reg + TOT_W'(wt_reg);
            end
            else
            begin
                err_next = 1'b1;
            end
        end
    end

    // Table occupancy and weight total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            val_reg <= item_value;
            wt_reg  <= item_weight;
        end
        rnd_reg     <= rnd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        found_reg   <= found_next;
        err_reg     <= err_next;
        sel_val_reg <= sel_val_next;
        sel_wt_reg  <= sel_wt_next;
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            chosen_reg  <= (op_reg == OP_DRAW && found_reg) ? sel_val_reg : '0;
            wout_reg    <= (op_reg == OP_QUERY && found_reg) ? sel_wt_reg : '0;
            hit_reg     <= found_reg && (op_reg != OP_CLEAR);
            err_out_reg <= err_reg && (op_reg == OP_SET);
        end
    end

    assign chosen_value     = chosen_reg;
    assign weight_out       = wout_reg;
    assign hit              = hit_reg;
    assign table_full_error = err_out_reg;

endmodule

>>> rtl/core/weighted_random_selector_unit.sv
// A draw reduces the random word modulo the weight total, then walks the table to the first entry
// whose cumulative range holds the remainder; set and query walk for a matching value; clear resets.
// One item in flight: each item runs the 32-step remainder unit (draws only) and the table walk,
// which reads each entry through the registered read port (S_RD) before checking it (S_CHK).
// The next item is taken while the previous result beat waits on out_stall.
// Reset (rst_n, asynchronous) empties the table and zeroes the total; table RAM is not cleared.
module weighted_random_selector_unit
    import wrs_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic signed [VAL_W-1:0] item_value,
    input  logic [WT_W-1:0]         item_weight,
    input  logic [RND_W-1:0]        random_word,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] chosen_value,
    output logic [WT_W-1:0]         weight_out,
    output logic                    hit,
    output logic                    table_full_error
);

    wrs_cmd_t  cmd;
    wrs_stat_t stat;

    wrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    wrs_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .opcode           (opcode),
        .item_value       (item_value),
        .item_weight      (item_weight),
        .random_word      (random_word),
        .chosen_value     (chosen_value),
        .weight_out       (weight_out),
        .hit              (hit),
        .table_full_error (table_full_error),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
